FILE: src/pidl_pkg.sv
`default_nettype none

package pidl_pkg;

    // default number of list entries
    localparam int unsigned PIDL_CAPACITY = 64;

    // command codes
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_APPEND = 2'd2;
    localparam logic [1:0] CMD_REMOVE = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // width of the position and count fields
    localparam int unsigned POS_W = 7;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [POS_W-1:0]  position;
        logic signed [31:0] item_value;
    } pidl_in_t;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [POS_W-1:0]  count;
        logic [1:0]        status;
    } pidl_out_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic rd_pos;
        logic shift_init;
        logic shift_step;
        logic wr_ins;
        logic wr_app;
        logic dec;
        logic capture;
        logic respond;
    } pidl_ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       range_err;
        logic       full_err;
        logic       no_shift;
        logic       shift_last;
    } pidl_sts_t;

endpackage

`default_nettype wire

FILE: src/pidl_ram.sv
`default_nettype none

module pidl_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/pidl_datapath.sv
`default_nettype none

module pidl_datapath
    import pidl_pkg::*;
#(
    parameter int unsigned CAPACITY = PIDL_CAPACITY
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pidl_in_t  request,
    input  wire pidl_ctl_t ctl,
    output pidl_sts_t      sts,
    output logic           done,
    output pidl_out_t      result
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned LW = (CW > POS_W) ? CW : POS_W;

    pidl_in_t        req_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic            mv_pend_reg, mv_pend_next;
    logic [AW-1:0]   mv_addr_reg, mv_addr_next;
    pidl_out_t       result_reg, result_next;
    logic            done_reg;

    logic [LW-1:0]   pos_ext, cnt_ext, cnt_next_ext;
    logic [AW-1:0]   pos_a, cnt_a, cntm1_a;
    logic            is_ins;
    logic            full;
    logic [1:0]      st_code;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [31:0]     ram_wdata, ram_rdata;

    always_comb
    begin
        pos_ext = LW'(req_reg.position);
        cnt_ext = LW'(count_reg);
        pos_a   = pos_ext[AW-1:0];
        cnt_a   = count_reg[AW-1:0];
        cntm1_a = AW'(count_reg - CW'(1));
        is_ins  = (req_reg.cmd == CMD_INSERT);
        full    = (count_reg == CW'(CAPACITY));

        sts.op = req_reg.cmd;
        case (req_reg.cmd)
            CMD_INSERT:
            begin
                sts.range_err = (pos_ext > cnt_ext);
                sts.full_err  = full;
                sts.no_shift  = (pos_ext == cnt_ext);
            end
            CMD_APPEND:
            begin
                sts.range_err = 1'b0;
                sts.full_err  = full;
                sts.no_shift  = 1'b1;
            end
            CMD_REMOVE:
            begin
                sts.range_err = (pos_ext >= cnt_ext);
                sts.full_err  = 1'b0;
                sts.no_shift  = ((pos_ext + LW'(1)) == cnt_ext);
            end
            default:
            begin
                sts.range_err = (pos_ext >= cnt_ext);
                sts.full_err  = 1'b0;
                sts.no_shift  = 1'b1;
            end
        endcase
        sts.shift_last = is_ins ? (ptr_reg == pos_a) : (ptr_reg == cntm1_a);

        if (sts.range_err)
        begin
            st_code = ST_RANGE;
        end
        else if (sts.full_err)
        begin
            st_code = ST_FULL;
        end
        else
        begin
            st_code = ST_OK;
        end
    end

    // element move pipeline: read one entry, then write the registered read data to its neighbor
    always_comb
    begin
        ptr_next     = ptr_reg;
        mv_pend_next = 1'b0;
        mv_addr_next = mv_addr_reg;
        if (ctl.shift_init)
        begin
            ptr_next = is_ins ? cntm1_a : AW'(pos_a + AW'(1));
        end
        else if (ctl.shift_step)
        begin
            mv_pend_next = 1'b1;
            mv_addr_next = is_ins ? AW'(ptr_reg + AW'(1)) : AW'(ptr_reg - AW'(1));
            ptr_next     = is_ins ? AW'(ptr_reg - AW'(1)) : AW'(ptr_reg + AW'(1));
        end

        ram_re    = ctl.rd_pos | ctl.shift_step;
        ram_raddr = ctl.rd_pos ? pos_a : ptr_reg;

        ram_we    = mv_pend_reg | ctl.wr_ins | ctl.wr_app;
        if (mv_pend_reg)
        begin
            ram_waddr = mv_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (ctl.wr_ins)
        begin
            ram_waddr = pos_a;
            ram_wdata = req_reg.item_value;
        end
        else
        begin
            ram_waddr = cnt_a;
            ram_wdata = req_reg.item_value;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.wr_ins || ctl.wr_app)
        begin
            count_next = CW'(count_reg + CW'(1));
        end
        else if (ctl.dec)
        begin
            count_next = CW'(count_reg - CW'(1));
        end
        cnt_next_ext = LW'(count_next);

        result_next.read_data = ctl.capture ? ram_rdata : '0;
        result_next.count     = cnt_next_ext[POS_W-1:0];
        result_next.status    = st_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            mv_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            mv_pend_reg <= mv_pend_next;
            done_reg    <= ctl.respond;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= request;
        end
        if (ctl.respond)
        begin
            result_reg <= result_next;
        end
        ptr_reg     <= ptr_next;
        mv_addr_reg <= mv_addr_next;
    end

    pidl_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mv_pend_reg |-> !(ctl.wr_ins || ctl.wr_app))
        else $error("move write collides with commit write");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held two cycles");
`endif

endmodule

`default_nettype wire

FILE: src/pidl_ctrl.sv
`default_nettype none

module pidl_ctrl
    import pidl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire pidl_sts_t sts,
    output pidl_ctl_t      ctl,
    output logic           busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_READ_WAIT,
        S_SHIFT,
        S_DRAIN,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    busy_next  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.range_err || sts.full_err)
                begin
                    ctl.respond = 1'b1;
                end
                else
                begin
                    case (sts.op)
                        CMD_READ:
                        begin
                            ctl.rd_pos = 1'b1;
                        end
                        CMD_INSERT:
                        begin
                            ctl.wr_ins     = sts.no_shift;
                            ctl.respond    = sts.no_shift;
                            ctl.shift_init = !sts.no_shift;
                        end
                        CMD_APPEND:
                        begin
                            ctl.wr_app  = 1'b1;
                            ctl.respond = 1'b1;
                        end
                        default:
                        begin
                            ctl.dec        = sts.no_shift;
                            ctl.respond    = sts.no_shift;
                            ctl.shift_init = !sts.no_shift;
                        end
                    endcase
                end
                if (ctl.respond)
                begin
                    busy_next  = 1'b0;
                    state_next = S_IDLE;
                end
                else if (ctl.rd_pos)
                begin
                    state_next = S_READ_WAIT;
                end
                else
                begin
                    state_next = S_SHIFT;
                end
            end
            S_READ_WAIT:
            begin
                ctl.capture = 1'b1;
                ctl.respond = 1'b1;
                busy_next   = 1'b0;
                state_next  = S_IDLE;
            end
            S_SHIFT:
            begin
                ctl.shift_step = 1'b1;
                if (sts.shift_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                ctl.wr_ins  = (sts.op == CMD_INSERT);
                ctl.dec     = (sts.op != CMD_INSERT);
                ctl.respond = 1'b1;
                busy_next   = 1'b0;
                state_next  = S_IDLE;
            end
            default:
            begin
                busy_next  = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: src/positional_insert_delete_list_unit.sv
// channel   | signals                  | transfer
// ----------+--------------------------+-------------------------------------
// command   | start, busy, request     | edge with start high and busy low
// result    | done, result             | edge ending the cycle with done high
//
// sequence: error, append, insert at the end, remove of the last element are
//   answered from the check state; read first waits for the store; an insert
//   or remove that moves elements moves one element per cycle through the
//   single read port and single write port of the element store
// reset: rst_n clears the count, controller and strobe; the store itself
//   is not cleared, entries at or above the count are never read
// stalls: the receiver cannot stall; done lasts one cycle per transfer
`default_nettype none

module positional_insert_delete_list_unit
    import pidl_pkg::*;
#(
    parameter int unsigned CAPACITY = PIDL_CAPACITY
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire pidl_in_t request,
    output logic          done,
    output pidl_out_t     result
);

    // command and status between controller and datapath
    pidl_ctl_t ctl;
    pidl_sts_t sts;

    // controller: sequences check, read, element moves and commit
    pidl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    // datapath: command register, count, move pipeline, store, result register
    pidl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;
    import pidl_pkg::*;

    // list depth of the default build, the handshake limits and the phase length
    localparam int DEPTH        = PIDL_CAPACITY;
    localparam int QUIET_LIMIT  = 1000;
    localparam int FLUSH_CYCLES = DEPTH + 16;
    localparam int PHASE_ITEMS  = 250;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    logic      done;
    pidl_in_t  request;
    pidl_out_t result;

    positional_insert_delete_list_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // shadow copy of the list, advanced once per command transfer
    logic signed [31:0] list_words [0:DEPTH-1];
    int                 list_len = 0;

    // one expected answer per accepted command, oldest first
    pidl_out_t          expected_answers[$];

    int error_count  = 0;
    int quiet_cycles = 0;
    int idle_pct     = 0;

    // run statistics for the closing summary
    int n_cmds       = 0;
    int n_by_cmd [4] = '{0, 0, 0, 0};
    int n_range      = 0;
    int n_full       = 0;
    int peak_len     = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // apply one command to the shadow list and return the answer it must give
    function automatic pidl_out_t apply_list_cmd(input pidl_in_t req);
        pidl_out_t ans;
        int        p;
        begin
            ans = '0;
            p   = int'(req.position);
            case (req.cmd)
                CMD_READ:
                begin
                    if (p < list_len)
                        ans.read_data = list_words[p];
                    else
                        ans.status = ST_RANGE;
                end
                CMD_INSERT:
                begin
                    // range check wins over the full check
                    if (p > list_len)
                        ans.status = ST_RANGE;
                    else if (list_len >= DEPTH)
                        ans.status = ST_FULL;
                    else
                    begin
                        for (int i = list_len; i > p; i--)
                            list_words[i] = list_words[i-1];
                        list_words[p] = req.item_value;
                        list_len++;
                    end
                end
                CMD_APPEND:
                begin
                    if (list_len >= DEPTH)
                        ans.status = ST_FULL;
                    else
                    begin
                        list_words[list_len] = req.item_value;
                        list_len++;
                    end
                end
                CMD_REMOVE:
                begin
                    if (p >= list_len)
                        ans.status = ST_RANGE;
                    else
                    begin
                        for (int i = p; i + 1 < list_len; i++)
                            list_words[i] = list_words[i+1];
                        list_len--;
                    end
                end
                default:
                begin
                end
            endcase
            ans.count = list_len[POS_W-1:0];
            return ans;
        end
    endfunction

    // monitor: results are checked before the same edge's command transfer
    // is predicted, so a stray strobe is never matched against it
    always @(posedge clk)
    begin : monitor
        pidl_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    error_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (result.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %0d, got %0d",
                               want.read_data, result.read_data);
                        error_count++;
                    end
                    if (result.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, result.count);
                        error_count++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, result.status);
                        error_count++;
                    end
                end
            end

            if (start && !busy)
            begin
                want = apply_list_cmd(request);
                expected_answers.push_back(want);
                n_cmds++;
                n_by_cmd[request.cmd]++;
                if (want.status == ST_RANGE)
                    n_range++;
                if (want.status == ST_FULL)
                    n_full++;
                if (list_len > peak_len)
                    peak_len = list_len;
            end

            // watchdog on cycles without any transfer
            if (done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // every sender task is entered and left at a falling edge; start stays
    // high on return so the next command can follow without a gap
    task automatic send_cmd(input logic [1:0] c, input int p, input logic signed [31:0] v);
        int          gap;
        logic [63:0] noise;
        begin
            gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                noise   = {$urandom, $urandom};
                start   <= 1'b0;
                request <= noise[$bits(pidl_in_t)-1:0];
                repeat (gap) @(negedge clk);
            end
            start            <= 1'b1;
            request.cmd      <= c;
            request.position <= p[POS_W-1:0];
            request.item_value <= v;
            do
                @(posedge clk);
            while (busy);
            @(negedge clk);
        end
    endtask

    // sender holds off until every outstanding result has come back
    task automatic wait_drain();
        begin
            start <= 1'b0;
            while (expected_answers.size() != 0)
                @(negedge clk);
        end
    endtask

    // half the time the two extremes, zero or minus one, else anything
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0;
            3:       return -32'sh1;
            default: return $urandom;
        endcase
    endfunction

    // empty list errors, inserts at both ends and the middle, reads, removes
    task automatic test_directed();
        begin
            send_cmd(CMD_READ,   0,  $urandom);
            send_cmd(CMD_REMOVE, 0,  $urandom);
            send_cmd(CMD_INSERT, 1,  32'sh1234_5678);
            send_cmd(CMD_INSERT, 64, 32'sh1234_5678);
            send_cmd(CMD_APPEND, 64, 32'sh7fff_ffff);
            send_cmd(CMD_APPEND, 0,  32'sh8000_0000);
            send_cmd(CMD_INSERT, 0,  -32'sh1);
            send_cmd(CMD_INSERT, 3,  32'sh0);
            send_cmd(CMD_INSERT, 2,  32'sh5555_5555);
            send_cmd(CMD_INSERT, 5,  32'shaaaa_aaaa);
            for (int i = 0; i < 6; i++)
                send_cmd(CMD_READ, i, $urandom);
            // reads, a remove and an insert at or past the end
            send_cmd(CMD_READ,   6,  $urandom);
            send_cmd(CMD_READ,   64, $urandom);
            send_cmd(CMD_REMOVE, 7,  $urandom);
            send_cmd(CMD_INSERT, 7,  32'sh0f0f_0f0f);
            // remove last, first, then middle
            send_cmd(CMD_REMOVE, 5,  $urandom);
            send_cmd(CMD_REMOVE, 0,  $urandom);
            send_cmd(CMD_REMOVE, 1,  $urandom);
            send_cmd(CMD_READ,   0,  $urandom);
            send_cmd(CMD_READ,   1,  $urandom);
            wait_drain();
        end
    endtask

    // fill to capacity, hit the full answers, then shift the whole list
    task automatic test_full_store();
        begin
            while (list_len < DEPTH)
                send_cmd(CMD_APPEND, $urandom_range(0, 64), pick_value());
            send_cmd(CMD_APPEND, 0,         pick_value());
            send_cmd(CMD_INSERT, DEPTH,     pick_value());
            send_cmd(CMD_INSERT, 0,         pick_value());
            send_cmd(CMD_READ,   DEPTH - 1, $urandom);
            send_cmd(CMD_READ,   DEPTH,     $urandom);
            send_cmd(CMD_REMOVE, DEPTH,     $urandom);
            send_cmd(CMD_REMOVE, DEPTH - 1, $urandom);
            send_cmd(CMD_INSERT, 0,         pick_value());
            send_cmd(CMD_REMOVE, 0,         $urandom);
            send_cmd(CMD_INSERT, DEPTH - 1, pick_value());
            send_cmd(CMD_READ,   0,         $urandom);
            send_cmd(CMD_READ,   DEPTH - 1, $urandom);
            wait_drain();
        end
    endtask

    // empty the list from random places, then read from the empty list
    task automatic test_drain_to_empty();
        begin
            while (list_len > 0)
                send_cmd(CMD_REMOVE, $urandom_range(0, list_len - 1), $urandom);
            send_cmd(CMD_READ,   0, $urandom);
            send_cmd(CMD_REMOVE, 0, $urandom);
            wait_drain();
        end
    endtask

    // random walk that swings between growing and shrinking the list so
    // both the full and the empty ends are reached again and again
    task automatic test_random_walk(input int n_items);
        logic       growing;
        int         phase_left;
        int         roll;
        int         p;
        logic [1:0] c;
        begin
            growing    = 1'b1;
            phase_left = $urandom_range(40, 120);
            for (int k = 0; k < n_items; k++)
            begin
                if (phase_left == 0)
                begin
                    growing    = ~growing;
                    phase_left = $urandom_range(40, 120);
                end
                phase_left--;
                roll = $urandom_range(99);
                if (growing)
                    c = (roll < 35) ? CMD_APPEND : (roll < 65) ? CMD_INSERT :
                        (roll < 80) ? CMD_REMOVE : CMD_READ;
                else
                    c = (roll < 55) ? CMD_REMOVE : (roll < 65) ? CMD_INSERT :
                        (roll < 75) ? CMD_APPEND : CMD_READ;

                // mostly legal positions with the ends favored, some noise
                roll = $urandom_range(99);
                if (c == CMD_APPEND || roll >= 85)
                    p = $urandom_range(0, 64);
                else if (c == CMD_INSERT)
                    p = (roll < 10) ? 0 : (roll < 20) ? list_len : $urandom_range(0, list_len);
                else if (list_len == 0)
                    p = 0;
                else
                    p = (roll < 10) ? 0 : (roll < 20) ? list_len - 1 :
                        $urandom_range(0, list_len - 1);

                send_cmd(c, p, (c == CMD_INSERT || c == CMD_APPEND) ? pick_value() : $urandom);
            end
            wait_drain();
        end
    endtask

    initial
    begin
        start   = 1'b0;
        request = '0;
        rst_n   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_full_store();
        test_drain_to_empty();

        // idle phases: back to back, sender idle often, sender idle sometimes
        idle_pct = 0;
        test_random_walk(PHASE_ITEMS);
        idle_pct = 55;
        test_random_walk(PHASE_ITEMS);
        idle_pct = 22;
        test_random_walk(PHASE_ITEMS);

        // let any late strobe show up before the verdict
        wait_drain();
        repeat (FLUSH_CYCLES) @(negedge clk);

        $display("covered %0d commands: %0d read, %0d insert, %0d append, %0d remove",
                 n_cmds, n_by_cmd[CMD_READ], n_by_cmd[CMD_INSERT],
                 n_by_cmd[CMD_APPEND], n_by_cmd[CMD_REMOVE]);
        $display("%0d out-of-range and %0d full answers, list length peaked at %0d",
                 n_range, n_full, peak_len);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
